@@ rtl/wsts_pkg.sv @@
// Package for the window sum target search block: sizes, codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package wsts_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int ELEM_BITS = 16;
  localparam int IDX_BITS  = $clog2(MAX_LEN);
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int SUM_BITS  = 26;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // Register index (byte address divided by four)
  localparam logic REG_TARGET = 1'b0;

  // Result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pop_needed;
    logic emit_needed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/wsts_if.sv @@
// Valid/ready channel interfaces for the element input and the result output.
// Depends on wsts_pkg for field widths.
`default_nettype none

interface wsts_in_if;
  import wsts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] element_value;
  logic                 last_item;

  modport source (output valid, output element_value, output last_item, input ready);
  modport sink   (input valid, input element_value, input last_item, output ready);
endinterface

interface wsts_out_if;
  import wsts_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [IDX_BITS-1:0] first_index;
  logic [IDX_BITS-1:0] last_index;

  modport source (output valid, output status, output first_index, output last_index,
                  input ready);
  modport sink   (input valid, input status, input first_index, input last_index,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/wsts_regs.sv @@
// APB-style configuration register file holding the target sum.
// Depends on wsts_pkg.
`default_nettype none

module wsts_regs
  import wsts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output logic      [SUM_BITS-1:0]  target_sum
);

  logic sel_target;

  assign pready     = 1'b1;
  assign sel_target = (paddr[ADDR_BITS-1:2] == REG_TARGET);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && sel_target) begin
      target_sum <= pwdata[SUM_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_target) begin
      prdata = {{(DATA_BITS-SUM_BITS){1'b0}}, target_sum};
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsts_ctrl.sv @@
// Controller state machine: accepts an element, steps the window shrink loop,
// then retires the item. Depends on wsts_pkg.
`default_nettype none

module wsts_ctrl
  import wsts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.pop_needed) begin
          cmd.pop    = 1'b1;
          state_next = S_WAIT;
        end else if (!sts.emit_needed || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      // let the store read catch up with the advanced window start
      S_WAIT: begin
        state_next = S_CHECK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/wsts_dp.sv @@
// Datapath: element store, window total and pointers, per-set flags and the
// result register. Depends on wsts_pkg.
`default_nettype none

module wsts_dp
  import wsts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [ELEM_BITS-1:0] element_value,
  input  wire logic                 last_item,
  input  wire logic [SUM_BITS-1:0]  target_sum,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic      [1:0]           status,
  output logic      [IDX_BITS-1:0]  first_index,
  output logic      [IDX_BITS-1:0]  last_index
);

  logic [ELEM_BITS-1:0] store [MAX_LEN];
  logic [ELEM_BITS-1:0] rd_data;

  logic [SUM_BITS-1:0]  total;
  logic [IDX_BITS-1:0]  start;
  logic [IDX_BITS-1:0]  newest;
  logic [CNT_BITS-1:0]  count;
  logic                 match_done;
  logic                 overlong;
  logic                 active;
  logic                 last_r;

  logic                 found;
  logic                 can_add;

  assign can_add = !match_done && !overlong && !count[CNT_BITS-1];
  assign found   = active && (total == target_sum);

  assign sts.pop_needed  = active && (total > target_sum) && (start < newest);
  assign sts.emit_needed = found || (last_r && !match_done);
  assign sts.out_free    = !out_valid || out_ready;

  // Element store: one write port at the fill position, one registered read
  // at the window start.
  always_ff @(posedge clk) begin
    if (cmd.accept && can_add) begin
      store[count[IDX_BITS-1:0]] <= element_value;
    end
    rd_data <= store[start];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      start      <= '0;
      newest     <= '0;
      count      <= '0;
      match_done <= 1'b0;
      overlong   <= 1'b0;
      active     <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_r <= last_item;
        active <= can_add;
        if (can_add) begin
          total  <= total + {{(SUM_BITS-ELEM_BITS){1'b0}}, element_value};
          newest <= count[IDX_BITS-1:0];
          count  <= count + 1'b1;
        end else if (!match_done && !overlong) begin
          overlong <= 1'b1;
        end
      end
      if (cmd.pop) begin
        total <= total - {{(SUM_BITS-ELEM_BITS){1'b0}}, rd_data};
        start <= start + 1'b1;
      end
      if (cmd.finish) begin
        active <= 1'b0;
        if (last_r) begin
          total      <= '0;
          start      <= '0;
          count      <= '0;
          match_done <= 1'b0;
          overlong   <= 1'b0;
        end else if (found) begin
          match_done <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && sts.emit_needed) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && sts.emit_needed) begin
      if (found) begin
        status      <= ST_FOUND;
        first_index <= start;
        last_index  <= newest;
      end else begin
        status      <= overlong ? ST_TOO_LONG : ST_NOT_FOUND;
        first_index <= '0;
        last_index  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/window_sum_target_search.sv @@
// Window sum target search: first contiguous run of a set that sums to target.
// Flow: an element is accepted in idle; the check state then drops elements
// from the window start through the wait state and registers any result due as it retires.
// A new element is taken only after the last one retires; each element is dropped at most once.
// Reset: rst (synchronous) clears the FSM, window state, flags and target;
// the element store is not cleared and needs no clearing pass.
`default_nettype none

module window_sum_target_search
  import wsts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  wsts_in_if.sink                   in_ch,
  wsts_out_if.source                out_ch,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready
);

  logic [SUM_BITS-1:0] target_sum;
  cmd_t                cmd;
  sts_t                sts;

  // Target register on the configuration port; the user must write it only while idle (the block has no check)
  wsts_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .target_sum (target_sum)
  );

  // Sequencer: take a transfer in idle, drop window elements one by one via the wait state,
  // retire once no result is due or the output register is free to take one
  wsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, running total, pointers and the result register; the result
  // register parts the output side from the sequencer
  wsts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .element_value (in_ch.element_value),
    .last_item     (in_ch.last_item),
    .target_sum    (target_sum),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .status        (out_ch.status),
    .first_index   (out_ch.first_index),
    .last_index    (out_ch.last_index)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_window_sum_target_search.sv @@
// Self-checking testbench for window_sum_target_search: element sets in, run reports out.
// Depends on wsts_pkg (rtl/wsts_pkg.sv) and the channel interfaces (rtl/wsts_if.sv).
// Target written over APB; reports checked against an in-bench shadow of the two-pointer search.
`timescale 1ns / 1ps

module tb_window_sum_target_search;
  import wsts_pkg::*;

  // Settling wait for the block to finish silent work after the last report:
  // the check state plus a pop and wait step per dropped element, at most a full window.
  localparam int SETTLE_CYCLES  = 2 * MAX_LEN + 16;
  // Cycles without any transfer before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 550;

  localparam logic [ADDR_BITS-1:0] TARGET_ADDR = {REG_TARGET, 2'b00};
  localparam logic [ADDR_BITS-1:0] SPARE_ADDR  = {~REG_TARGET, 2'b00};

  typedef struct packed {
    logic [1:0]          status;
    logic [IDX_BITS-1:0] first_index;
    logic [IDX_BITS-1:0] last_index;
  } search_report_t;

  // How the target of a random phase is chosen, and with it the shape of its sets.
  typedef enum int {
    GOAL_ZERO,
    GOAL_MAX,
    GOAL_SMALL,
    GOAL_PLANTED,
    GOAL_WIDE
  } goal_mode_t;

  // Shadow of the search: tracks the window of the current set, predicts each
  // report and holds the reports still awaited from the block.
  class window_search_shadow;
    logic [ELEM_BITS-1:0] kept [MAX_LEN];
    logic [SUM_BITS-1:0]  target_sum;
    logic [SUM_BITS:0]    total;
    int unsigned          head;
    int unsigned          count;
    bit                   matched;
    bit                   overflowed;
    search_report_t       awaited_reports[$];
    int unsigned          errors;
    int unsigned          elements_seen;
    int unsigned          sets_closed;
    int unsigned          reports_checked;
    int unsigned          found_seen;
    int unsigned          missing_seen;
    int unsigned          overlong_seen;

    function new();
      target_sum = '0;
      clear_set();
    endfunction

    function void clear_set();
      total      = '0;
      head       = 0;
      count      = 0;
      matched    = 1'b0;
      overflowed = 1'b0;
    endfunction

    function void write_register(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] word);
      if (addr[ADDR_BITS-1:2] == REG_TARGET) target_sum = word[SUM_BITS-1:0];
    endfunction

    function int unsigned pending();
      return awaited_reports.size();
    endfunction

    // Note one accepted element and queue the report it causes, if any.
    function void absorb_element(logic [ELEM_BITS-1:0] value, logic closes_set);
      int unsigned    k;
      search_report_t rep;
      elements_seen++;
      if (!matched && !overflowed) begin
        if (count >= MAX_LEN) begin
          overflowed = 1'b1;
        end else begin
          k        = count;
          kept[k]  = value;
          total    = total + {{(SUM_BITS + 1 - ELEM_BITS){1'b0}}, value};
          count    = k + 1;
          // shrink from the old end while over target and more than one element held
          while (total > {1'b0, target_sum} && head < k) begin
            total = total - {{(SUM_BITS + 1 - ELEM_BITS){1'b0}}, kept[head]};
            head++;
          end
          if (total == {1'b0, target_sum}) begin
            matched         = 1'b1;
            rep.status      = ST_FOUND;
            rep.first_index = head[IDX_BITS-1:0];
            rep.last_index  = k[IDX_BITS-1:0];
            awaited_reports.push_back(rep);
            found_seen++;
          end
        end
      end
      if (closes_set) begin
        if (!matched) begin
          rep.status      = overflowed ? ST_TOO_LONG : ST_NOT_FOUND;
          rep.first_index = '0;
          rep.last_index  = '0;
          awaited_reports.push_back(rep);
          if (overflowed) overlong_seen++;
          else missing_seen++;
        end
        sets_closed++;
        clear_set();
      end
    endfunction

    // Compare one report from the block with the oldest one awaited.
    function void compare_report(search_report_t got);
      search_report_t want;
      reports_checked++;
      if (awaited_reports.size() == 0) begin
        $display("%0t: report with none awaited: status %0d first %0d last %0d",
                 $time, got.status, got.first_index, got.last_index);
        errors++;
        return;
      end
      want = awaited_reports.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.first_index !== want.first_index) begin
        $display("%0t: first_index mismatch: expected %0d, got %0d",
                 $time, want.first_index, got.first_index);
        errors++;
      end
      if (got.last_index !== want.last_index) begin
        $display("%0t: last_index mismatch: expected %0d, got %0d",
                 $time, want.last_index, got.last_index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  wsts_in_if  in_ch();
  wsts_out_if out_ch();

  window_search_shadow shadow;

  // Sender state: what the last push left on the channel, and whether to skip gaps.
  bit          tx_offering = 1'b0;
  bit          tx_quiet    = 1'b0;
  int unsigned phases_run  = 0;
  int unsigned quiet_cycles;

  window_sum_target_search dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check every report transfer against the shadow.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      shadow.compare_report(search_report_t'{out_ch.status, out_ch.first_index,
                                             out_ch.last_index});
    end
  end

  // Abandon the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d reports still awaited",
               $time, WATCHDOG_LIMIT, shadow.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Report sink: after each transfer draw a random stall, at times none, skip stalls
  // in every third stretch of reports, and twice hold off for a long stretch so
  // the block fills up and back-pressures its input.
  initial begin : report_sink
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        taken++;
        if (taken == 25 || taken == 60) stall = 400;
        else if ((taken / 15) % 3 == 2) stall = 0;
        else stall = $urandom_range(0, 9);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  function automatic logic [ELEM_BITS-1:0] rand_elem(input int unsigned hi);
    logic [31:0] raw;
    raw = $urandom_range(0, hi);
    return raw[ELEM_BITS-1:0];
  endfunction

  // Offer one element after a random gap and hold it until the transfer.
  task automatic push_element(input logic [ELEM_BITS-1:0] value, input logic closes_set);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      if (tx_offering) in_ch.valid <= 1'b0;
      tx_offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= value;
    in_ch.last_item     <= closes_set;
    tx_offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    shadow.absorb_element(value, closes_set);
  endtask

  // Drop valid after the final transfer of a burst.
  task automatic end_burst();
    if (tx_offering) in_ch.valid <= 1'b0;
    tx_offering = 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait for every awaited report.
  task automatic drain_results();
    end_burst();
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.write_register(addr, word);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Read the target back and compare with the shadow copy.
  task automatic apb_read_target();
    logic [DATA_BITS-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TARGET_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = {{(DATA_BITS - SUM_BITS){1'b0}}, shadow.target_sum};
    if (prdata !== want) begin
      $display("%0t: target read-back mismatch: expected %0h, got %0h", $time, want, prdata);
      shadow.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block go idle, then load a new target and read it back.
  task automatic reprogram(input logic [DATA_BITS-1:0] word);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(TARGET_ADDR, word);
    apb_read_target();
    phases_run++;
  endtask

  // Build one random set suited to the phase's target and send it.
  task automatic random_set(input goal_mode_t mode, input logic [SUM_BITS-1:0] goal);
    logic [ELEM_BITS-1:0] elems[$];
    int unsigned          len;
    int unsigned          left;
    int unsigned          pick;
    case (mode)
      GOAL_ZERO: begin
        len = $urandom_range(1, 8);
        repeat (len) elems.push_back(($urandom_range(0, 1) == 0) ? '0 : rand_elem(65535));
      end
      GOAL_SMALL: begin
        len = $urandom_range(1, 16);
        repeat (len) elems.push_back(($urandom_range(0, 7) == 0) ? rand_elem(65535)
                                                                  : rand_elem(goal));
      end
      GOAL_PLANTED: begin
        if ($urandom_range(0, 4) != 0) begin
          // random lead-in, a run that sums exactly to the goal, random tail
          len = $urandom_range(0, 4);
          repeat (len) elems.push_back(rand_elem(65535));
          left = goal;
          while (left != 0) begin
            pick = $urandom_range(1, (left < 65535) ? left : 65535);
            elems.push_back(rand_elem(0) | pick[ELEM_BITS-1:0]);
            left = left - pick;
          end
          len = $urandom_range(0, 3);
          repeat (len) elems.push_back(rand_elem(65535));
        end else begin
          len = $urandom_range(1, 10);
          repeat (len) elems.push_back(rand_elem(65535));
        end
      end
      default: begin
        len = $urandom_range(1, 12);
        repeat (len) elems.push_back(rand_elem(65535));
      end
    endcase
    foreach (elems[i]) push_element(elems[i], i == elems.size() - 1);
  endtask

  initial begin : stimulus
    goal_mode_t          mode;
    logic [DATA_BITS-1:0] word;
    int unsigned         random_goal;
    int unsigned         phase_start;
    int unsigned         phase_no;
    int unsigned         set_no;
    shadow = new();
    in_ch.valid         <= 1'b0;
    in_ch.element_value <= '0;
    in_ch.last_item     <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Target after reset is zero: only a lone zero element can match.
    apb_read_target();
    push_element(16'd5, 1'b0);
    push_element(16'd0, 1'b1);       // drop the 5, lone zero matches on the last item
    push_element(16'd0, 1'b1);       // one-element set matching at index 0
    push_element(16'd3, 1'b0);
    push_element(16'd4, 1'b1);       // no zero anywhere: not found

    reprogram(32'd10);
    push_element(16'd3, 1'b0);
    push_element(16'd7, 1'b0);       // match here, the rest of the set is silent
    push_element(16'd9, 1'b0);
    push_element(16'd1, 1'b1);
    push_element(16'd4, 1'b0);
    push_element(16'd6, 1'b1);       // match on the last item reports found
    push_element(16'd20, 1'b0);      // oversized single element is kept
    push_element(16'd5, 1'b0);
    push_element(16'd5, 1'b1);
    push_element(16'd11, 1'b1);      // lone element above target: not found

    // Largest target, loaded from a word with the upper bits set; a write to the
    // unused address must leave it alone.
    reprogram(32'hFFFF_FFFF);
    apb_write(SPARE_ADDR, 32'h0000_0010);
    apb_read_target();
    push_element(16'hFFFF, 1'b0);
    push_element(16'hFFFF, 1'b0);
    push_element(16'h0000, 1'b1);

    // Random phases: each draws a target and sends sets shaped for it.
    random_goal = shadow.elements_seen + RANDOM_ITEMS;
    phase_no = 0;
    while (shadow.elements_seen < random_goal) begin
      mode = (phase_no < 5) ? goal_mode_t'(phase_no) : goal_mode_t'($urandom_range(0, 4));
      case (mode)
        GOAL_ZERO:    word = 32'd0;
        GOAL_MAX:     word = 32'hFFFF_FFFF;
        GOAL_SMALL:   word = $urandom_range(1, 60);
        GOAL_PLANTED: word = $urandom_range(1000, 200000);
        default:      word = $urandom;
      endcase
      tx_quiet = (phase_no % 3 == 1);
      reprogram(word);
      phase_start = shadow.elements_seen;
      set_no = 0;
      while (shadow.elements_seen - phase_start < 70 && shadow.elements_seen < random_goal) begin
        random_set(mode, shadow.target_sum);
        set_no++;
        // hold the sender once mid-phase until the block has caught up
        if (phase_no == 2 && set_no == 2) drain_results();
      end
      phase_no++;
    end

    // Full-length set matching on its final element: run at indices 1022..1023.
    tx_quiet = 1'b0;
    reprogram(32'd5);
    repeat (MAX_LEN - 1) push_element(16'd2, 1'b0);
    push_element(16'd3, 1'b1);

    // Overlong set with an unreachable target: the extra elements are ignored
    // and the last one reports too long.
    reprogram(32'hFFFF_FFFF);
    repeat (MAX_LEN + 1) push_element(rand_elem(65535), 1'b0);
    push_element(rand_elem(65535), 1'b1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d elements in %0d sets over %0d target settings; checked %0d reports.",
             shadow.elements_seen, shadow.sets_closed, phases_run, shadow.reports_checked);
    $display("Expected reports: %0d found, %0d not found, %0d too long.",
             shadow.found_seen, shadow.missing_seen, shadow.overlong_seen);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
